// ===== design/assert_macros.svh =====
// assertion macros shared by the utf8 validator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/utf8v_pkg.sv =====
// types and constants shared by the utf8 validator modules
package utf8v_pkg;

    // byte classes decided by the front end
    typedef enum logic [2:0] {
        CLS_ASCII_OK = 3'd0,
        CLS_CTRL     = 3'd1,
        CLS_CONT     = 3'd2,
        CLS_BAD_LEAD = 3'd3,
        CLS_LEAD2    = 3'd4,
        CLS_LEAD3    = 3'd5,
        CLS_LEAD4    = 3'd6
    } cls_t;

    // one queued item: end marker or classified byte with its payload bits
    typedef struct packed {
        logic       is_end;
        cls_t       cls;
        logic [5:0] bits;
    } entry_t;

    // error kinds reported at end of text
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_CONTROL    = 3'd1;
    localparam logic [2:0] ERR_BAD_LEAD   = 3'd2;
    localparam logic [2:0] ERR_BAD_CONT   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd4;
    localparam logic [2:0] ERR_CODE_POINT = 3'd5;

    // minimum code point class of a sequence
    localparam logic [1:0] MIN_CLS_2B = 2'd0;
    localparam logic [1:0] MIN_CLS_3B = 2'd1;
    localparam logic [1:0] MIN_CLS_4B = 2'd2;

    localparam int unsigned ACC_W = 21;

    // queue depth, a power of two
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

endpackage

// ===== design/utf8v_front.sv =====
// front end: accepts bytes and end markers and classifies each byte
module utf8v_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // text_byte
    input  logic              s_tlast,   // action: end of text
    input  logic              s_tuser,   // multiline
    output logic              push_valid,
    input  logic              push_ready,
    output utf8v_pkg::entry_t push_entry
);

    logic              f_valid_reg, f_valid_next;
    utf8v_pkg::entry_t f_entry_reg, f_entry_next;
    utf8v_pkg::entry_t cls_entry;
    logic              take;
    logic              ws_ok;

    assign s_tready   = !f_valid_reg || push_ready;
    assign take       = s_tvalid && s_tready;
    assign push_valid = f_valid_reg;
    assign push_entry = f_entry_reg;

    always_comb begin
        ws_ok = s_tuser && (s_tdata == 8'h09 || s_tdata == 8'h0a || s_tdata == 8'h0d);
        cls_entry.is_end = s_tlast;
        cls_entry.bits   = s_tdata[5:0];
        if (s_tlast) begin
            cls_entry.cls = utf8v_pkg::CLS_ASCII_OK;
        end else if (!s_tdata[7]) begin
            if ((s_tdata < 8'h20 && !ws_ok) || s_tdata == 8'h7f) begin
                cls_entry.cls = utf8v_pkg::CLS_CTRL;
            end else begin
                cls_entry.cls = utf8v_pkg::CLS_ASCII_OK;
            end
        end else if (s_tdata[7:6] == 2'b10) begin
            cls_entry.cls = utf8v_pkg::CLS_CONT;
        end else if (s_tdata >= 8'hc2 && s_tdata <= 8'hdf) begin
            cls_entry.cls  = utf8v_pkg::CLS_LEAD2;
            cls_entry.bits = {1'b0, s_tdata[4:0]};
        end else if (s_tdata >= 8'he0 && s_tdata <= 8'hef) begin
            cls_entry.cls  = utf8v_pkg::CLS_LEAD3;
            cls_entry.bits = {2'b0, s_tdata[3:0]};
        end else if (s_tdata >= 8'hf0 && s_tdata <= 8'hf4) begin
            cls_entry.cls  = utf8v_pkg::CLS_LEAD4;
            cls_entry.bits = {3'b0, s_tdata[2:0]};
        end else begin
            cls_entry.cls = utf8v_pkg::CLS_BAD_LEAD;
        end
    end

    always_comb begin
        f_valid_next = f_valid_reg;
        f_entry_next = f_entry_reg;
        if (take) begin
            f_valid_next = 1'b1;
            f_entry_next = cls_entry;
        end else if (push_ready) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        f_entry_reg <= f_entry_next;
    end

endmodule

// ===== design/utf8v_fifo.sv =====
// short queue of classified items between front and back
`include "assert_macros.svh"

module utf8v_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  utf8v_pkg::entry_t push_entry,
    output logic              pop_valid,
    input  logic              pop_ready,
    output utf8v_pkg::entry_t pop_entry
);

    utf8v_pkg::entry_t                  mem_reg [utf8v_pkg::QDEPTH];
    logic [utf8v_pkg::QAW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [utf8v_pkg::QAW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [utf8v_pkg::QCW-1:0]          count_reg, count_next;
    logic                               do_push, do_pop;

    assign push_ready = count_reg < utf8v_pkg::QCW'(utf8v_pkg::QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + utf8v_pkg::QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + utf8v_pkg::QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + utf8v_pkg::QCW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - utf8v_pkg::QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= utf8v_pkg::QCW'(utf8v_pkg::QDEPTH), "queue count above depth")

endmodule

// ===== design/utf8v_back.sv =====
// back end: utf8 decode state, error tracking and verdict register
`include "assert_macros.svh"

module utf8v_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  utf8v_pkg::entry_t pop_entry,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata    // text_valid, error_kind[2:0], zero pad
);

    logic                          failed_reg, failed_next;
    logic [1:0]                    pend_reg, pend_next;
    logic [utf8v_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [1:0]                    min_cls_reg, min_cls_next;
    logic [2:0]                    first_err_reg, first_err_next;
    logic                          out_valid_reg, out_valid_next;
    logic [2:0]                    out_kind_reg, out_kind_next;

    logic                          do_pop;
    logic [utf8v_pkg::ACC_W-1:0]   acc_shift;
    logic [utf8v_pkg::ACC_W-1:0]   minimum;
    logic [1:0]                    pend_dec;
    logic [2:0]                    end_kind;

    assign pop_ready = !pop_entry.is_end || !out_valid_reg || m_tready;
    assign do_pop    = pop_valid && pop_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0, out_kind_reg, out_kind_reg == utf8v_pkg::ERR_NONE};

    assign acc_shift = {acc_reg[utf8v_pkg::ACC_W-7:0], pop_entry.bits};
    assign pend_dec  = pend_reg - 2'd1;

    always_comb begin
        unique case (min_cls_reg)
            utf8v_pkg::MIN_CLS_2B: minimum = utf8v_pkg::ACC_W'(24'h80);
            utf8v_pkg::MIN_CLS_3B: minimum = utf8v_pkg::ACC_W'(24'h800);
            default:               minimum = utf8v_pkg::ACC_W'(24'h10000);
        endcase
    end

    always_comb begin
        if (failed_reg) begin
            end_kind = first_err_reg;
        end else if (pend_reg != 2'd0) begin
            end_kind = utf8v_pkg::ERR_TRUNCATED;
        end else begin
            end_kind = utf8v_pkg::ERR_NONE;
        end
    end

    always_comb begin
        failed_next    = failed_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        min_cls_next   = min_cls_reg;
        first_err_next = first_err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        if (do_pop && pop_entry.is_end) begin
            out_valid_next = 1'b1;
            out_kind_next  = end_kind;
            failed_next    = 1'b0;
            pend_next      = 2'd0;
            acc_next       = '0;
            min_cls_next   = utf8v_pkg::MIN_CLS_2B;
            first_err_next = utf8v_pkg::ERR_NONE;
        end else if (do_pop && !failed_reg) begin
            if (pend_reg != 2'd0) begin
                if (pop_entry.cls != utf8v_pkg::CLS_CONT) begin
                    failed_next    = 1'b1;
                    first_err_next = utf8v_pkg::ERR_BAD_CONT;
                end else begin
                    acc_next  = acc_shift;
                    pend_next = pend_dec;
                    // sequence complete: range, surrogate and c1 checks
                    if (pend_dec == 2'd0) begin
                        if (acc_shift < minimum
                                || acc_shift > utf8v_pkg::ACC_W'(24'h10ffff)
                                || (acc_shift >= utf8v_pkg::ACC_W'(24'hd800)
                                    && acc_shift <= utf8v_pkg::ACC_W'(24'hdfff))) begin
                            failed_next    = 1'b1;
                            first_err_next = utf8v_pkg::ERR_CODE_POINT;
                        end else if (acc_shift >= utf8v_pkg::ACC_W'(24'h80)
                                && acc_shift <= utf8v_pkg::ACC_W'(24'h9f)) begin
                            failed_next    = 1'b1;
                            first_err_next = utf8v_pkg::ERR_CONTROL;
                        end
                    end
                end
            end else begin
                unique case (pop_entry.cls)
                    utf8v_pkg::CLS_ASCII_OK: begin
                    end
                    utf8v_pkg::CLS_CTRL: begin
                        failed_next    = 1'b1;
                        first_err_next = utf8v_pkg::ERR_CONTROL;
                    end
                    utf8v_pkg::CLS_LEAD2: begin
                        acc_next     = utf8v_pkg::ACC_W'(pop_entry.bits);
                        min_cls_next = utf8v_pkg::MIN_CLS_2B;
                        pend_next    = 2'd1;
                    end
                    utf8v_pkg::CLS_LEAD3: begin
                        acc_next     = utf8v_pkg::ACC_W'(pop_entry.bits);
                        min_cls_next = utf8v_pkg::MIN_CLS_3B;
                        pend_next    = 2'd2;
                    end
                    utf8v_pkg::CLS_LEAD4: begin
                        acc_next     = utf8v_pkg::ACC_W'(pop_entry.bits);
                        min_cls_next = utf8v_pkg::MIN_CLS_4B;
                        pend_next    = 2'd3;
                    end
                    default: begin
                        // stray continuation or invalid lead
                        failed_next    = 1'b1;
                        first_err_next = utf8v_pkg::ERR_BAD_LEAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failed_reg    <= 1'b0;
            pend_reg      <= 2'd0;
            acc_reg       <= '0;
            min_cls_reg   <= utf8v_pkg::MIN_CLS_2B;
            first_err_reg <= utf8v_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            failed_reg    <= failed_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            min_cls_reg   <= min_cls_next;
            first_err_reg <= first_err_next;
            out_valid_reg <= out_valid_next;
        end
        out_kind_reg <= out_kind_next;
    end

    `ASSERT_ALWAYS(a_failed_kind, aclk, aresetn, failed_reg == (first_err_reg != utf8v_pkg::ERR_NONE), "failed flag and error kind disagree")
    `ASSERT_NEXT(a_end_clears, aclk, aresetn, do_pop && pop_entry.is_end, !failed_reg && pend_reg == 2'd0 && m_tvalid, "end of text did not clear state")
    `ASSERT_IMPLIES(a_pop_safe, aclk, aresetn, do_pop && pop_entry.is_end && out_valid_reg, m_tready, "verdict overwritten while stalled")

endmodule

// ===== design/utf8_text_validator.sv =====
// top level of the utf8 text validator
// Checks a text fed one byte per transaction (s_tdata byte, s_tuser multiline, s_tlast marks
// end of text with the byte ignored) and returns one verdict transaction per end of text:
// m_tdata[0] text valid, m_tdata[3:1] first error kind (0 none, 1 control char, 2 bad lead,
// 3 bad continuation, 4 truncated, 5 bad code point). The block sustains one transaction per
// cycle while no end marker is held back by a verdict waiting on m_tready; each item passes a
// classify register in the front end, a two-entry queue and the decode step of the back end,
// and the verdict register of the back end then holds the result. The decode state loop in the
// back end sets that rate, and the queue lets input keep flowing while a verdict waits on m_tready.
module utf8_text_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // text_byte
    input  logic       s_tlast,   // action: end of text
    input  logic       s_tuser,   // multiline
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // text_valid, error_kind[2:0], zero pad
);

    logic              push_valid, push_ready;
    utf8v_pkg::entry_t push_entry;
    logic              pop_valid, pop_ready;
    utf8v_pkg::entry_t pop_entry;

    utf8v_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    utf8v_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    utf8v_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
